/* sv/sorted_set_insert_lookup_top_defines.svh */
// Assertion macros for the sorted set block.
// Included by the modules that carry concurrent checks; needs nothing else.
`ifndef SORTED_SET_INSERT_LOOKUP_TOP_DEFINES_SVH
`define SORTED_SET_INSERT_LOOKUP_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define SSIL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("sorted set check failed");

// Next-cycle implication, disabled while reset is asserted
`define SSIL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("sorted set check failed");

`endif

/* sv/ssil_pkg.sv */
// Shared types and constants for the sorted set block.
// No dependencies; imported by the controller, the datapath and the top level.
package ssil_pkg;

	// Field widths fixed by the interface
	localparam int CMD_W     = 2;
	localparam int KEY_W     = 32;
	localparam int RIDX_W    = 4;
	localparam int POS_W     = 4;
	localparam int CNT_OUT_W = 5;

	// Default store depth
	localparam int DEFAULT_CAPACITY = 16;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

	// Controller to datapath commands
	typedef struct packed {
		logic load;     // capture the accepted transaction
		logic compare;  // register per-cell compare flags
		logic commit;   // update the store and load the result register
	} ssil_cmd_t;

endpackage

/* sv/ssil_ctrl.sv */
// Controller state machine of the sorted set block.
// Depends on ssil_pkg; drives the datapath through ssil_cmd_t.
module ssil_ctrl
	import ssil_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output ssil_cmd_t dp_cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CMP  = 2'd1;
	localparam logic [1:0] ST_EXE  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       slot_free;

	// Result register may be reloaded when empty or being taken this cycle
	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// Next state and commands
	always_comb begin
		state_d        = state_q;
		dp_cmd.load    = 1'b0;
		dp_cmd.compare = 1'b0;
		dp_cmd.commit  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					dp_cmd.load = 1'b1;
					state_d     = ST_CMP;
				end
			end
			ST_CMP: begin
				dp_cmd.compare = 1'b1;
				state_d        = ST_EXE;
			end
			ST_EXE: begin
				if (slot_free) begin
					dp_cmd.commit = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State and output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (dp_cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* sv/ssil_dpath.sv */
// Datapath of the sorted set block: row of compare-and-shift cells,
// entry count, place encoder and result register. Depends on ssil_pkg.
`include "sorted_set_insert_lookup_top_defines.svh"
module ssil_dpath
	import ssil_pkg::*;
#(
	parameter int CAPACITY = DEFAULT_CAPACITY
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ssil_cmd_t               dp_cmd,
	input  logic [CMD_W-1:0]        cmd,
	input  logic signed [KEY_W-1:0] key_value,
	input  logic [RIDX_W-1:0]       read_index,
	output logic                    hit,
	output logic                    inserted,
	output logic                    full_drop,
	output logic [POS_W-1:0]        position,
	output logic [CNT_OUT_W-1:0]    entry_count,
	output logic signed [KEY_W-1:0] read_data,
	output logic                    read_valid
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > RIDX_W) ? CNT_W : RIDX_W;

	// Cells and captured transaction
	logic signed [KEY_W-1:0] entry_q [CAPACITY];
	logic [CNT_W-1:0]        count_q;
	logic [CMD_W-1:0]        cmd_q;
	logic signed [KEY_W-1:0] key_q;
	logic [RIDX_W-1:0]       ridx_q;

	// Per-cell compare flags
	logic [CAPACITY-1:0] lt_s1;
	logic [CAPACITY-1:0] eq_s1;

	logic [CAPACITY-1:0] edge_w;
	logic [IDX_W-1:0]    place;
	logic                found;
	logic                full;
	logic                is_ins;
	logic                is_look;
	logic                do_ins;
	logic                rd_ok;

	// Result register
	logic                    hit_q;
	logic                    inserted_q;
	logic                    full_drop_q;
	logic [POS_W-1:0]        position_q;
	logic [CNT_OUT_W-1:0]    entry_count_q;
	logic signed [KEY_W-1:0] read_data_q;
	logic                    read_valid_q;

	// Capture the accepted transaction
	always_ff @(posedge clk) begin
		if (dp_cmd.load) begin
			cmd_q  <= cmd;
			key_q  <= key_value;
			ridx_q <= read_index;
		end
	end

	// Each occupied cell compares its own value with the key
	always_ff @(posedge clk) begin
		if (dp_cmd.compare) begin
			for (int i = 0; i < CAPACITY; i++) begin
				lt_s1[i] <= (CNT_W'(i) < count_q) && (entry_q[i] < key_q);
				eq_s1[i] <= (CNT_W'(i) < count_q) && (entry_q[i] == key_q);
			end
		end
	end

	// Less-than flags form a thermometer; its edge marks the sorted place
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			if (i == 0) begin
				edge_w[i] = !lt_s1[i];
			end else begin
				edge_w[i] = lt_s1[(i > 0) ? i - 1 : 0] && !lt_s1[i];
			end
		end
	end

	always_comb begin
		place = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			place = place | (edge_w[i] ? IDX_W'(i) : IDX_W'(0));
		end
	end

	assign found   = |eq_s1;
	assign full    = (count_q == CNT_W'(CAPACITY));
	assign is_ins  = (cmd_q == CMD_INSERT);
	assign is_look = (cmd_q == CMD_LOOKUP);
	assign do_ins  = is_ins && !found && !full;
	assign rd_ok   = (cmd_q == CMD_READ) && (CMP_W'(ridx_q) < CMP_W'(count_q));

	// Shift larger entries up one cell and drop the key into its place
	always_ff @(posedge clk) begin
		if (dp_cmd.commit && do_ins) begin
			for (int i = 0; i < CAPACITY; i++) begin
				if (IDX_W'(i) == place) begin
					entry_q[i] <= key_q;
				end else if (i > 0 && IDX_W'(i) > place) begin
					entry_q[i] <= entry_q[(i > 0) ? i - 1 : 0];
				end
			end
		end
	end

	// Entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (dp_cmd.commit && do_ins) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (dp_cmd.commit) begin
			hit_q         <= (is_ins || is_look) && found;
			inserted_q    <= do_ins;
			full_drop_q   <= is_ins && !found && full;
			position_q    <= (((is_ins || is_look) && found) || do_ins) ?
			                 POS_W'(place) : '0;
			entry_count_q <= CNT_OUT_W'(count_q + CNT_W'(do_ins));
			read_data_q   <= rd_ok ? entry_q[IDX_W'(ridx_q)] : '0;
			read_valid_q  <= rd_ok;
		end
	end

	assign hit         = hit_q;
	assign inserted    = inserted_q;
	assign full_drop   = full_drop_q;
	assign position    = position_q;
	assign entry_count = entry_count_q;
	assign read_data   = read_data_q;
	assign read_valid  = read_valid_q;

	// Checks
	`SSIL_ASSERT_IMPL(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(CAPACITY))
	`SSIL_ASSERT_IMPL(a_single_place, clk, arst_n, dp_cmd.commit, $onehot0(edge_w))
	`SSIL_ASSERT_NEXT(a_count_step, clk, arst_n, !(dp_cmd.commit && do_ins),
		count_q == $past(count_q))

endmodule

/* sv/sorted_set_insert_lookup_top.sv */
// Sorted set of signed 32-bit values with insert, lookup and read.
// Input and result channels use valid/ready. A transaction is taken only
// while the block is free (in_ready high); it then goes through the cell
// compare, then resolves the place and updates the store at commit, where
// the result is loaded into the output register. A new transaction is taken
// only after the last one has committed, following the controller sequence
// idle, compare, commit.
// Commands: insert (a duplicate reports hit, a full store reports
// full_drop), lookup (hit and position) and read of the entry at
// read_index (read_valid when below the count).
// If the receiver stalls, the result holds in the output register; the next
// transaction is still accepted and compared, and waits before its commit
// until the register is free.
// Reset (arst_n low) empties the store and clears the handshake state;
// stored values are not cleared, as only occupied cells are ever read.
// Depends on ssil_pkg, ssil_ctrl and ssil_dpath.
module sorted_set_insert_lookup_top
	import ssil_pkg::*;
#(
	parameter int CAPACITY = DEFAULT_CAPACITY
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [CMD_W-1:0]        cmd,
	input  logic signed [KEY_W-1:0] key_value,
	input  logic [RIDX_W-1:0]       read_index,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    hit,
	output logic                    inserted,
	output logic                    full_drop,
	output logic [POS_W-1:0]        position,
	output logic [CNT_OUT_W-1:0]    entry_count,
	output logic signed [KEY_W-1:0] read_data,
	output logic                    read_valid
);

	ssil_cmd_t ctrl_cmd;

	// Controller
	ssil_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.dp_cmd    (ctrl_cmd)
	);

	// Datapath
	ssil_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.dp_cmd      (ctrl_cmd),
		.cmd         (cmd),
		.key_value   (key_value),
		.read_index  (read_index),
		.hit         (hit),
		.inserted    (inserted),
		.full_drop   (full_drop),
		.position    (position),
		.entry_count (entry_count),
		.read_data   (read_data),
		.read_valid  (read_valid)
	);

endmodule
